// File: rtl/sipm_pkg.sv
`default_nettype none

package sipm_pkg;

    localparam int MAX_NAME_LEN = 32;
    localparam int NUM_PATTERNS = 60;
    localparam int POS_W        = $clog2(MAX_NAME_LEN);
    localparam int PAT_BYTES    = 19;
    localparam int CODE_W       = 6;

    localparam logic [CODE_W-1:0] BAD_CODE = CODE_W'(50);

    typedef logic [7:0]             t_char;
    typedef logic [POS_W-1:0]       t_pos;
    typedef logic [CODE_W-1:0]      t_code;
    typedef logic [8*PAT_BYTES-1:0] t_pat_text;

    // Right-aligned, zero padded on the left.
    localparam t_pat_text PAT_TEXT [NUM_PATTERNS] = '{
        "v", "c", "e", "f", "i", "m", "l", "s", "t",
        "Accept", "Accept-Encoding", "Accept-Language", "Allow", "Allow-Events",
        "Also", "Authorization", "Call-ID", "Contact", "Content-Encoding",
        "Content-Length", "Content-Type", "CSeq", "Date", "Encryption", "Event",
        "Expires", "From", "Hide", "Min-Expires", "Max-Forwards", "Organization",
        "Proxy-Authenticate", "Proxy-Authorization", "Proxy-Require", "Priority",
        "Require", "Retry-After", "Response-Key", "Record-Route", "Refer-To",
        "Refer-Sub", "Referred-By", "Route", "RAck", "RSeq", "Server",
        "Service-Route", "Subject", "SIP-ETag", "SIP-If-Match",
        "Subscription-State", "SUBSCRIPTION-STATE", "Supported", "Timestamp",
        "Unsupported", "To", "User-Agent", "Via", "Warning", "WWW-Authenticate"
    };

    localparam t_code PAT_CODE [NUM_PATTERNS] = '{
        6'd47, 6'd11, 6'd9,  6'd17, 6'd7,  6'd8,  6'd10, 6'd38, 6'd44,
        6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
        6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19,
        6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
        6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
        6'd40, 6'd41, 6'd41, 6'd42, 6'd43, 6'd45, 6'd44, 6'd46, 6'd47, 6'd48,
        6'd49
    };

    // SIP-ETag, SIP-If-Match and both Subscription-State spellings.
    localparam logic [NUM_PATTERNS-1:0] PAT_EXACT = 60'h00F_0000_0000_0000;

    function automatic t_char fold_char(input t_char c);
        t_char r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    function automatic int pat_len(input int idx);
        int n;
        n = 0;
        for (int b = 0; b < PAT_BYTES; b++) begin
            if (PAT_TEXT[idx][8*b +: 8] != 8'h00) begin
                n++;
            end
        end
        return n;
    endfunction

    // Expected byte of pattern idx at position pos, folded where the
    // pattern is case-insensitive; zero past the end.
    function automatic t_char pat_char(input int idx, input t_pos pos);
        int    len;
        int    p;
        t_char ch;
        len = pat_len(idx);
        p   = int'(pos);
        ch  = 8'h00;
        if (p < len) begin
            ch = PAT_TEXT[idx][8*(len-1-p) +: 8];
            if (!PAT_EXACT[idx]) begin
                ch = fold_char(ch);
            end
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sipm_char_rom.sv
`default_nettype none

module sipm_char_rom
    import sipm_pkg::*;
(
    input  wire  logic  i_clk,
    input  wire  t_pos  i_addr,
    output t_char       o_row [NUM_PATTERNS]
);

    t_char r_row [NUM_PATTERNS];

    // One column per pattern, registered read of the position row.
    for (genvar g = 0; g < NUM_PATTERNS; g++) begin : g_col
        always_ff @(posedge i_clk) begin
            r_row[g] <= pat_char(g, i_addr);
        end
        assign o_row[g] = r_row[g];
    end

endmodule

`default_nettype wire

// File: rtl/sip_header_name_matcher_core.sv
`default_nettype none

// Channel  Direction  Handshake          Payload
// in       input      i_valid / o_stall  i_name_char, i_last_char
// out      output     o_valid / i_stall  o_header_code, o_matched
//
// One char per cycle unless stalled; results leave the cycle after a last char.
// The pattern-character ROM is read one position ahead, so its registered row
// lines up with the next character. Synchronous reset restarts the name.
// Input stalls only while a result is held and the output is stalled.

module sip_header_name_matcher_core
    import sipm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    input  wire logic  [7:0] i_name_char,
    input  wire logic  i_last_char,
    output logic       o_valid,
    input  wire logic  i_stall,
    output logic [5:0] o_header_code,
    output logic       o_matched
);

    logic [NUM_PATTERNS-1:0] r_alive, n_alive;
    t_pos                    r_pos, n_pos;
    logic                    r_too_long, n_too_long;
    logic                    r_out_valid;
    t_code                   r_out_code;
    logic                    r_out_matched;

    t_char                   rom_row [NUM_PATTERNS];
    t_char                   c_fold;
    logic [NUM_PATTERNS-1:0] hit;
    logic [NUM_PATTERNS-1:0] alive_upd;
    logic [NUM_PATTERNS-1:0] fin;
    logic [POS_W:0]          pos_inc;
    logic                    accept_in;
    logic                    found;
    t_code                   code;

    sipm_char_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (n_pos),
        .o_row  (rom_row)
    );

    assign o_stall   = r_out_valid & i_stall;
    assign accept_in = i_valid & ~o_stall;
    assign c_fold    = fold_char(i_name_char);
    assign pos_inc   = {1'b0, r_pos} + (POS_W+1)'(1);

    for (genvar g = 0; g < NUM_PATTERNS; g++) begin : g_lane
        localparam int LEN = pat_len(g);
        if (PAT_EXACT[g]) begin : g_exact
            assign hit[g] = (rom_row[g] != 8'h00) && (i_name_char == rom_row[g]);
        end else begin : g_fold
            assign hit[g] = (rom_row[g] != 8'h00) && (c_fold == rom_row[g]);
        end
        assign fin[g] = alive_upd[g] && (pos_inc == (POS_W+1)'(LEN));
    end

    assign alive_upd = r_too_long ? '0 : (r_alive & hit);

    always_comb begin
        found = 1'b0;
        code  = BAD_CODE;
        for (int i = NUM_PATTERNS - 1; i >= 0; i--) begin
            if (fin[i]) begin
                found = 1'b1;
                code  = PAT_CODE[i];
            end
        end
    end

    always_comb begin
        n_alive    = r_alive;
        n_pos      = r_pos;
        n_too_long = r_too_long;
        if (!i_rst_n) begin
            n_alive    = '1;
            n_pos      = '0;
            n_too_long = 1'b0;
        end else if (accept_in) begin
            if (i_last_char) begin
                n_alive    = '1;
                n_pos      = '0;
                n_too_long = 1'b0;
            end else if (r_pos == t_pos'(MAX_NAME_LEN - 1)) begin
                n_alive    = '0;
                n_too_long = 1'b1;
            end else begin
                n_alive = alive_upd;
                n_pos   = pos_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_alive    <= n_alive;
        r_pos      <= n_pos;
        r_too_long <= n_too_long;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept_in && i_last_char) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in && i_last_char) begin
            r_out_code    <= code;
            r_out_matched <= found;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_header_code = r_out_code;
    assign o_matched     = r_out_matched;

endmodule

`default_nettype wire
